// ===== rtl/brhp_pkg.sv =====
// ----------------------------------------------------------------------------
// brhp_pkg - shared types and constants for the byte range header parser
// Field widths, verdict codes, reset value of the length ceiling and the
// case-folded "bytes=" prefix lookup.
// ----------------------------------------------------------------------------
package brhp_pkg;

   localparam int ByteW    = 8;
   localparam int FieldW   = 48;
   localparam int PrefixN  = 6;
   localparam int PosW     = 3;

   localparam int ReqDataW = 56;   // value_byte, object_size
   localparam int RspDataW = 96;   // range_offset, range_length
   localparam int RspUserW = 2;    // verdict

   localparam logic [FieldW-1:0] LIMIT_RESET = 48'd1048576;

   localparam logic [ByteW-1:0] CHAR_DASH  = 8'h2d;
   localparam logic [ByteW-1:0] CHAR_COMMA = 8'h2c;
   localparam logic [ByteW-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [ByteW-1:0] CHAR_NINE  = 8'h39;
   localparam logic [ByteW-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [ByteW-1:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [ByteW-1:0] CASE_BIT   = 8'h20;

   typedef enum logic [1:0] {
      VERDICT_IGNORE = 2'd0,
      VERDICT_PARTIAL = 2'd1,
      VERDICT_UNSAT  = 2'd2
   } verdict_type;

   // lowercase text of the prefix, one character per position
   function automatic logic [ByteW-1:0] lead_char(input logic [PosW-1:0] pos);
      logic [ByteW-1:0] c;
      c = '0;
      case (pos)
         3'd0:    c = 8'h62;   // b
         3'd1:    c = 8'h79;   // y
         3'd2:    c = 8'h74;   // t
         3'd3:    c = 8'h65;   // e
         3'd4:    c = 8'h73;   // s
         3'd5:    c = 8'h3d;   // =
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/byte_range_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// byte_range_header_parser_core - single-range Range header value parser
// Matches a case-insensitive "bytes=" prefix, then a suffix "-N", an open
// "A-" or a closed "A-B" form, and gives verdict, offset and clamped length
// after the last byte of the value.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  req     | in  | req_tvalid/tready    | tdata {object_size, value_byte}, tlast
//  rsp     | out | rsp_tvalid/tready    | tdata {range_length, range_offset},
//          |     |                      | tuser verdict
//  csr     | in  | csr_valid/csr_ready  | csr_data = range_limit
//
//  One header byte is taken per cycle while req_tready is high. The parse
//  state registers update on each beat; the last beat's final state is
//  captured into a snapshot stage and its verdict into the result register
//  behind it, which drives rsp. The verdict logic (compare, subtract, clamp)
//  between snapshot and result register sets the clock period.
//  Reset clears the parse state and both stages and loads range_limit with
//  1048576. A stalled rsp fills the result register and then the snapshot;
//  req_tready drops only while both hold a result.
//
module byte_range_header_parser_core #(
   parameter int SIZE_BITS = 48
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] value_byte, [55:8] object_size
   input  logic [brhp_pkg::ReqDataW-1:0]     req_tdata,
   input  logic                              req_tlast,

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [47:0] range_offset, [95:48] range_length
   output logic [brhp_pkg::RspDataW-1:0]     rsp_tdata,
   // [1:0] verdict
   output logic [brhp_pkg::RspUserW-1:0]     rsp_tuser,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [brhp_pkg::FieldW-1:0]       csr_data
);
   import brhp_pkg::*;

   // file sizes are masked to the smaller of the port width and SIZE_BITS
   localparam int SizeW = (SIZE_BITS < FieldW) ? SIZE_BITS : FieldW;
   // one spare bit: any number at or past 2^SizeW saturates above every size
   localparam int NumW  = SizeW + 1;
   localparam logic [SizeW-1:0] SizeOne = SizeW'(1);

   typedef enum logic [2:0] {
      PH_PREFIX,
      PH_START,
      PH_FIRST,
      PH_SECOND,
      PH_TAIL,
      PH_BAD
   } phase_type;

   // saturating acc * 10 + d
   function automatic logic [NumW-1:0] add_digit(input logic [NumW-1:0] acc,
                                                 input logic [3:0]      d);
      logic [NumW+3:0] prod;
      prod = {acc, 3'b000} + {2'b00, acc, 1'b0} + (NumW+4)'(d);
      if (prod[NumW+3:NumW] != 4'd0) begin
         return '1;
      end
      return prod[NumW-1:0];
   endfunction

   // parse state
   phase_type         phase_ff,  phase_in;
   logic [PosW-1:0]   pos_ff,    pos_in;
   logic [NumW-1:0]   first_ff,  first_in;
   logic [NumW-1:0]   cur_ff,    cur_in;
   logic              digit_ff,  digit_in;
   logic              comma_ff,  comma_in;
   logic              suffix_ff, suffix_in;

   // snapshot of the final parse state
   logic              snap_vld_ff;
   logic              snap_ok_ff;
   logic              snap_suffix_ff;
   logic              snap_digit_ff;
   logic [NumW-1:0]   snap_first_ff;
   logic [NumW-1:0]   snap_cur_ff;
   logic [SizeW-1:0]  snap_size_ff;

   // result register
   logic              rsp_vld_ff;
   verdict_type       verdict_ff, verdict_in;
   logic [FieldW-1:0] off_ff,     off_in;
   logic [FieldW-1:0] len_ff,     len_in;

   logic [FieldW-1:0] limit_ff;

   logic [ByteW-1:0]  in_byte;
   logic [ByteW-1:0]  low_byte;
   logic [SizeW-1:0]  in_size;
   logic              is_digit;
   logic [3:0]        digit_val;
   logic              req_go;
   logic              out_free;
   logic              snap_go;

   assign in_byte   = req_tdata[ByteW-1:0];
   assign in_size   = req_tdata[ByteW +: SizeW];
   assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
   assign digit_val = is_digit ? 4'(in_byte - CHAR_ZERO) : 4'd0;
   assign low_byte  = ((in_byte >= CHAR_UP_A) && (in_byte <= CHAR_UP_Z)) ?
                      (in_byte | CASE_BIT) : in_byte;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign snap_go    = snap_vld_ff && out_free;
   assign req_tready = !snap_vld_ff || out_free;
   assign req_go     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- parse
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      first_in  = first_ff;
      cur_in    = cur_ff;
      digit_in  = digit_ff;
      suffix_in = suffix_ff;
      comma_in  = comma_ff || (in_byte == CHAR_COMMA);
      case (phase_ff)
         PH_PREFIX: begin
            if (pos_ff < PosW'(PrefixN) && low_byte == lead_char(pos_ff)) begin
               pos_in = pos_ff + 1'b1;
               if (pos_ff == PosW'(PrefixN - 1)) begin
                  phase_in = PH_START;
               end
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_START: begin
            if (in_byte == CHAR_DASH) begin
               suffix_in = 1'b1;
               cur_in    = '0;
               digit_in  = 1'b0;
               phase_in  = PH_SECOND;
            end else if (is_digit) begin
               cur_in   = NumW'(digit_val);
               digit_in = 1'b1;
               phase_in = PH_FIRST;
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_FIRST: begin
            if (is_digit) begin
               cur_in = add_digit(cur_ff, digit_val);
            end else if (in_byte == CHAR_DASH) begin
               first_in = cur_ff;
               cur_in   = '0;
               digit_in = 1'b0;
               phase_in = PH_SECOND;
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_SECOND: begin
            if (is_digit) begin
               cur_in   = add_digit(cur_ff, digit_val);
               digit_in = 1'b1;
            end else begin
               phase_in = PH_TAIL;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PREFIX;
         pos_ff    <= '0;
         first_ff  <= '0;
         cur_ff    <= '0;
         digit_ff  <= 1'b0;
         comma_ff  <= 1'b0;
         suffix_ff <= 1'b0;
      end else if (req_go) begin
         if (req_tlast) begin
            // start the next header value from scratch
            phase_ff  <= PH_PREFIX;
            pos_ff    <= '0;
            first_ff  <= '0;
            cur_ff    <= '0;
            digit_ff  <= 1'b0;
            comma_ff  <= 1'b0;
            suffix_ff <= 1'b0;
         end else begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            first_ff  <= first_in;
            cur_ff    <= cur_in;
            digit_ff  <= digit_in;
            comma_ff  <= comma_in;
            suffix_ff <= suffix_in;
         end
      end
   end

   // ------------------------------------------------------------- snapshot
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_vld_ff <= 1'b0;
      end else if (req_go && req_tlast) begin
         snap_vld_ff <= 1'b1;
      end else if (snap_go) begin
         snap_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go && req_tlast) begin
         snap_ok_ff     <= !comma_in && (phase_in == PH_SECOND || phase_in == PH_TAIL);
         snap_suffix_ff <= suffix_in;
         snap_digit_ff  <= digit_in;
         snap_first_ff  <= first_in;
         snap_cur_ff    <= cur_in;
         snap_size_ff   <= in_size;
      end
   end

   // -------------------------------------------------------------- verdict
   always_comb begin
      logic [NumW-1:0]   size_ext;
      logic              cur_big;
      logic [SizeW-1:0]  last;
      logic [SizeW-1:0]  off;
      logic [SizeW-1:0]  len;
      logic [FieldW-1:0] len_wide;
      verdict_type       v;

      size_ext = NumW'(snap_size_ff);
      cur_big  = snap_cur_ff >= size_ext;
      last     = '0;
      off      = '0;
      len      = '0;
      v        = VERDICT_IGNORE;
      if (snap_ok_ff) begin
         if (snap_suffix_ff) begin
            if (snap_digit_ff && snap_cur_ff != '0 && snap_size_ff != '0) begin
               v   = VERDICT_PARTIAL;
               off = cur_big ? '0 : snap_size_ff - snap_cur_ff[SizeW-1:0];
               len = cur_big ? snap_size_ff : snap_cur_ff[SizeW-1:0];
            end
         end else begin
            // missing or oversized end falls back to the last file byte
            last = (!snap_digit_ff || cur_big) ? snap_size_ff - SizeOne :
                   snap_cur_ff[SizeW-1:0];
            if (snap_size_ff == '0 || snap_first_ff >= size_ext ||
                NumW'(last) < snap_first_ff) begin
               v = VERDICT_UNSAT;
            end else begin
               v   = VERDICT_PARTIAL;
               off = snap_first_ff[SizeW-1:0];
               len = last - snap_first_ff[SizeW-1:0] + SizeOne;
            end
         end
      end

      len_wide = FieldW'(len);
      if (len_wide > limit_ff) begin
         len_wide = limit_ff;
      end
      // a zero ceiling leaves nothing to send
      if (v == VERDICT_PARTIAL && len_wide == '0) begin
         v   = VERDICT_IGNORE;
         off = '0;
      end

      verdict_in = v;
      off_in     = FieldW'(off);
      len_in     = len_wide;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff <= snap_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_go) begin
         verdict_ff <= verdict_in;
         off_ff     <= off_in;
         len_ff     <= len_in;
      end
   end

   // -------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {len_ff, off_ff};
   assign rsp_tuser  = verdict_ff;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - byte range header parser core
// Streams Range header values into the parser one beat per character: a
// table of hand-picked headers first, then random headers that are mostly
// well formed with some noise. Table rows mostly carry the expected verdict,
// offset and length, a local parse model predicts the rest, and the result
// stream is compared in order under random stalls on both sides and several length ceilings.
// ----------------------------------------------------------------------------
module testbench;
   import brhp_pkg::*;

   localparam logic [FieldW-1:0] SIZE_MAX   = 48'hFFFF_FFFF_FFFF;
   localparam logic [63:0]       ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int                NUM_ROWS   = 27;
   localparam int                PHASE_BYTES = 55;
   localparam int                CYCLE_LIMIT = 200000;

   typedef enum logic [2:0] {
      SCAN_LEAD, SCAN_START, SCAN_FIRST, SCAN_SECOND, SCAN_TAIL, SCAN_DEAD
   } scan_state_type;

   typedef struct packed {
      verdict_type       verdict;
      logic [FieldW-1:0] offset;
      logic [FieldW-1:0] length;
   } range_answer_type;

   typedef struct packed {
      logic              set_limit;
      logic [FieldW-1:0] limit;
      logic [FieldW-1:0] size;
      logic              typed;
      verdict_type       verdict;
      logic [FieldW-1:0] offset;
      logic [FieldW-1:0] length;
   } header_case_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic [RspUserW-1:0] rsp_tuser;
   logic                csr_valid;
   logic                csr_ready;
   logic [FieldW-1:0]   csr_data;

   // parse model state
   scan_state_type    scan;
   logic [PosW-1:0]   lead_pos;
   logic [63:0]       first_num;
   logic [63:0]       cur_num;
   logic              digit_seen;
   logic              comma_seen;
   logic              suffix_form;
   logic [FieldW-1:0] limit_model;
   string             lead_text = "bytes=";

   range_answer_type  pending_answers[$];
   logic [7:0]        hdr_bytes[$];
   logic [FieldW-1:0] hdr_size;
   logic              typed_on;
   range_answer_type  typed_answer;
   logic              mismatch;
   logic              calm;
   logic              long_hold;
   int                cycles;
   int                bytes_sent;

   header_case_type case_rows [NUM_ROWS] = '{
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_PARTIAL, 48'd0, 48'd100},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_PARTIAL, 48'd10, 48'd10},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_PARTIAL, 48'd95, 48'd5},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_PARTIAL, 48'd0, 48'd100},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_PARTIAL, 48'd2, 48'd3},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd0, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd0, 1'b1, VERDICT_UNSAT, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd0, 1'b1, VERDICT_UNSAT, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_UNSAT, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_UNSAT, 48'd0, 48'd0},
      '{1'b0, 48'd0, SIZE_MAX, 1'b1, VERDICT_PARTIAL, 48'd0, LIMIT_RESET},
      '{1'b0, 48'd0, SIZE_MAX, 1'b1, VERDICT_UNSAT, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b1, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd3000, 1'b0, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, SIZE_MAX, 1'b0, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b0, 48'd0, 48'd100, 1'b0, VERDICT_IGNORE, 48'd0, 48'd0},
      '{1'b1, 48'd1, 48'd100, 1'b1, VERDICT_PARTIAL, 48'd0, 48'd1},
      '{1'b1, SIZE_MAX, SIZE_MAX, 1'b1, VERDICT_PARTIAL, 48'd0, SIZE_MAX}
   };

   string case_text [NUM_ROWS] = '{
      "bytes=0-", "BYTES=10-19", "bytes=-5", "bytes=-500", "bytes=0-0,5-9",
      "byt", "bYtEz=0-", "bytes=x", "bytes=5x-9", "bytes=2-4 junk",
      "bytes=-", "bytes=-0", "bytes=-7", "bytes=0-", "bytes=3-9",
      "bytes=100-", "bytes=9-5", "bytes=0-99999999999999999999999",
      "bytes=99999999999999999999999-", "bytes= 1-2", "bytes=+1-2", "bytes=",
      "bytes=17-4000", "Bytes=-123456789012", "bytes=50-\377x",
      "bytes=0-", "bytes=0-"
   };

   byte_range_header_parser_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // parse model: one header character per call, answer on the final one
   // ---------------------------------------------------------------------
   function automatic logic [63:0] push_digit(input logic [63:0] acc, input logic [63:0] d);
      if (acc > (ALL_ONES - d) / 64'd10)
         return ALL_ONES;
      return acc * 64'd10 + d;
   endfunction

   task automatic parse_char(input logic [7:0] c, input logic fin, input logic [FieldW-1:0] fsize,
                             output logic got, output range_answer_type ans);
      logic        is_digit;
      logic [63:0] d;
      logic [7:0]  low;
      logic [63:0] sz;
      logic [63:0] end_pos;
      logic [63:0] off;
      logic [63:0] len;
      verdict_type v;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d = is_digit ? 64'(c - CHAR_ZERO) : 64'd0;
      low = (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? (c | CASE_BIT) : c;
      if (c == CHAR_COMMA)
         comma_seen = 1'b1;
      case (scan)
         SCAN_LEAD: begin
            if (int'(lead_pos) < PrefixN && low == 8'(lead_text[int'(lead_pos)])) begin
               lead_pos = lead_pos + 1'b1;
               if (int'(lead_pos) == PrefixN)
                  scan = SCAN_START;
            end else begin
               scan = SCAN_DEAD;
            end
         end
         SCAN_START: begin
            if (c == CHAR_DASH) begin
               suffix_form = 1'b1;
               cur_num = '0;
               digit_seen = 1'b0;
               scan = SCAN_SECOND;
            end else if (is_digit) begin
               cur_num = d;
               digit_seen = 1'b1;
               scan = SCAN_FIRST;
            end else begin
               scan = SCAN_DEAD;
            end
         end
         SCAN_FIRST: begin
            if (is_digit) begin
               cur_num = push_digit(cur_num, d);
            end else if (c == CHAR_DASH) begin
               first_num = cur_num;
               cur_num = '0;
               digit_seen = 1'b0;
               scan = SCAN_SECOND;
            end else begin
               scan = SCAN_DEAD;
            end
         end
         SCAN_SECOND: begin
            if (is_digit) begin
               cur_num = push_digit(cur_num, d);
               digit_seen = 1'b1;
            end else begin
               scan = SCAN_TAIL;
            end
         end
         default: ;
      endcase

      got = fin;
      ans = '0;
      if (fin) begin
         sz = 64'(fsize);
         v = VERDICT_IGNORE;
         off = '0;
         len = '0;
         if (!comma_seen && (scan == SCAN_SECOND || scan == SCAN_TAIL)) begin
            if (suffix_form) begin
               if (digit_seen && cur_num != 0 && sz != 0) begin
                  off = (cur_num >= sz) ? 64'd0 : sz - cur_num;
                  len = sz - off;
                  v = VERDICT_PARTIAL;
               end
            end else begin
               end_pos = digit_seen ? cur_num : sz - 64'd1;
               if (sz == 0 || end_pos >= sz)
                  end_pos = sz - 64'd1;
               if (first_num >= sz || end_pos < first_num) begin
                  v = VERDICT_UNSAT;
               end else begin
                  off = first_num;
                  len = end_pos - first_num + 64'd1;
                  v = VERDICT_PARTIAL;
               end
            end
         end
         if (v == VERDICT_PARTIAL) begin
            if (len > 64'(limit_model))
               len = 64'(limit_model);
            if (len == 0) begin
               v = VERDICT_IGNORE;
               off = '0;
            end
         end
         ans.verdict = v;
         ans.offset  = off[FieldW-1:0];
         ans.length  = len[FieldW-1:0];
         scan = SCAN_LEAD;
         lead_pos = '0;
         first_num = '0;
         cur_num = '0;
         digit_seen = 1'b0;
         comma_seen = 1'b0;
         suffix_form = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // watch both streams and the register port at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch
      range_answer_type want;
      range_answer_type ans;
      logic             got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               $error("result beat with nothing pending: verdict %0d offset %0d length %0d",
                      rsp_tuser, rsp_tdata[FieldW-1:0], rsp_tdata[2*FieldW-1:FieldW]);
               mismatch = 1'b1;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tuser !== want.verdict) begin
                  $error("verdict: expected %0d, got %0d", want.verdict, rsp_tuser);
                  mismatch = 1'b1;
               end
               if (rsp_tdata[FieldW-1:0] !== want.offset) begin
                  $error("range_offset: expected %0d, got %0d", want.offset,
                         rsp_tdata[FieldW-1:0]);
                  mismatch = 1'b1;
               end
               if (rsp_tdata[2*FieldW-1:FieldW] !== want.length) begin
                  $error("range_length: expected %0d, got %0d", want.length,
                         rsp_tdata[2*FieldW-1:FieldW]);
                  mismatch = 1'b1;
               end
            end
         end
         if (csr_valid && csr_ready)
            limit_model = csr_data;
         if (req_tvalid && req_tready) begin
            parse_char(req_tdata[ByteW-1:0], req_tlast, req_tdata[ByteW+FieldW-1:ByteW], got, ans);
            if (got)
               pending_answers.push_back(typed_on ? typed_answer : ans);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side backpressure, with one long hold on request
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_tready = 1'b0;
            stall_left = stall_left - 1;
         end else if (long_hold) begin
            long_hold = 1'b0;
            stall_left = 79;
            rsp_tready = 1'b0;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_text(input string t);
      for (int i = 0; i < t.len(); i++)
         hdr_bytes.push_back(8'(t[i]));
   endtask

   function automatic string number_text(input logic [FieldW-1:0] sz);
      logic [63:0] v;
      string       t;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = 64'($urandom_range(0, 999));
         4, 5:       v = 64'(sz) + 64'($urandom_range(0, 4)) - 64'd2;
         6, 7:       v = {$urandom, $urandom} & 64'(SIZE_MAX);
         8:          v = {$urandom, $urandom};
         default:    return {"99999999999999999999", $sformatf("%0d", $urandom_range(0, 99999))};
      endcase
      t = $sformatf("%0d", v);
      if ($urandom_range(0, 7) == 0)
         t = {"00", t};
      return t;
   endfunction

   // drive one character beat; idle first now and then
   task automatic send_char(input logic [7:0] c, input logic fin, input logic [FieldW-1:0] sz);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {sz, c};
      req_tlast  = fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      bytes_sent = bytes_sent + 1;
   endtask

   task automatic send_header();
      for (int i = 0; i < hdr_bytes.size(); i++) begin
         if (i == hdr_bytes.size() - 1)
            send_char(hdr_bytes[i], 1'b1, hdr_size);
         else
            send_char(hdr_bytes[i], 1'b0, 48'({$urandom, $urandom}));
      end
      req_tvalid = 1'b0;
   endtask

   // drain, let the last result leave the pipe, then write the ceiling
   task automatic set_range_limit(input logic [FieldW-1:0] value);
      req_tvalid = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic make_header();
      logic [7:0] c;
      int         n;
      int         form;
      int         kind;
      hdr_bytes.delete();
      case ($urandom_range(0, 9))
         0:       hdr_size = '0;
         1, 2, 3, 4: hdr_size = 48'($urandom_range(1, 2000));
         5, 6, 7: hdr_size = 48'({$urandom, $urandom});
         8:       hdr_size = SIZE_MAX;
         default: hdr_size = 48'd1;
      endcase
      kind = $urandom_range(0, 19);
      if (kind < 18) begin
         n = (kind < 16) ? PrefixN : $urandom_range(1, PrefixN);
         for (int i = 0; i < n; i++) begin
            c = 8'(lead_text[i]);
            // fold some letters to upper case, never the equals sign
            if (i < PrefixN - 1 && $urandom_range(0, 1) == 1)
               c = c & ~CASE_BIT;
            hdr_bytes.push_back(c);
         end
         if (kind >= 16 && $urandom_range(0, 1) == 1)
            hdr_bytes[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
      end
      if (kind < 16) begin
         form = $urandom_range(0, 2);
         if (form == 2) begin
            hdr_bytes.push_back(CHAR_DASH);
            if ($urandom_range(0, 9) != 0)
               push_text(number_text(hdr_size));
         end else begin
            push_text(number_text(hdr_size));
            hdr_bytes.push_back(CHAR_DASH);
            if (form == 0)
               push_text(number_text(hdr_size));
         end
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) hdr_bytes.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) == 0)
            hdr_bytes[$urandom_range(0, hdr_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 14) == 0)
            hdr_bytes.insert($urandom_range(0, hdr_bytes.size()), CHAR_COMMA);
      end else if (kind >= 18) begin
         repeat ($urandom_range(1, 10)) hdr_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : main
      logic [FieldW-1:0] lim;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      typed_on   = 1'b0;
      typed_answer = '0;
      mismatch   = 1'b0;
      calm       = 1'b0;
      long_hold  = 1'b0;
      cycles     = 0;
      bytes_sent = 0;
      scan = SCAN_LEAD;
      lead_pos = '0;
      first_num = '0;
      cur_num = '0;
      digit_seen = 1'b0;
      comma_seen = 1'b0;
      suffix_form = 1'b0;
      limit_model = LIMIT_RESET;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         if (case_rows[r].set_limit)
            set_range_limit(case_rows[r].limit);
         hdr_bytes.delete();
         push_text(case_text[r]);
         hdr_size = case_rows[r].size;
         typed_on = case_rows[r].typed;
         typed_answer = '{case_rows[r].verdict, case_rows[r].offset, case_rows[r].length};
         send_header();
      end
      typed_on = 1'b0;

      for (int stage = 0; stage < 4; stage++) begin
         case (stage)
            0:       lim = 48'($urandom_range(1, 5000));
            1:       lim = SIZE_MAX;
            2:       lim = 48'd1;
            default: lim = 48'({$urandom, $urandom});
         endcase
         if (lim == 0)
            lim = 48'd1;
         set_range_limit(lim);
         // hold the result side long while headers keep coming
         if (stage == 0)
            long_hold = 1'b1;
         if (stage == 3)
            calm = 1'b1;
         bytes_sent = 0;
         while (bytes_sent < PHASE_BYTES) begin
            make_header();
            send_header();
         end
      end

      while (pending_answers.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (!mismatch && pending_answers.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/brhp_pkg.sv
rtl/byte_range_header_parser_core.sv
sim/testbench.sv
